// ----- src/sray_pkg.sv -----
// ----------------------------------------------------------------------------
// sray_pkg
// Shared types, constants and bitboard helpers for the sliding ray attack
// generator: direction codes, file wrap masks and directional shifts.
// ----------------------------------------------------------------------------
package sray_pkg;

	localparam int unsigned BOARD_SQUARES = 64;
	localparam int unsigned SQUARE_W      = 6;
	localparam int unsigned NUM_DIRS      = 8;

	typedef logic [BOARD_SQUARES-1:0] bb_t;
	typedef logic [SQUARE_W-1:0]      square_t;

	// Ray directions; orthogonal ones first, diagonal ones after
	typedef enum logic [2:0] {
		DIR_UP    = 3'd0,  // +8
		DIR_DOWN  = 3'd1,  // -8
		DIR_RIGHT = 3'd2,  // +1
		DIR_LEFT  = 3'd3,  // -1
		DIR_NE    = 3'd4,  // +9
		DIR_NW    = 3'd5,  // +7
		DIR_SE    = 3'd6,  // -7
		DIR_SW    = 3'd7   // -9
	} dir_t;

	localparam bb_t FILE_A = 64'h0101_0101_0101_0101;
	localparam bb_t FILE_H = 64'h8080_8080_8080_8080;

	// Occluded fill state: generator and propagator per direction
	typedef struct packed {
		bb_t [NUM_DIRS-1:0] gen;
		bb_t [NUM_DIRS-1:0] pro;
	} fill_t;

	// Squares a one-step move in direction d may land on without wrapping
	function automatic bb_t wrap_mask(dir_t d);
		bb_t m;
		unique case (d)
			DIR_RIGHT, DIR_NE, DIR_SE: m = ~FILE_A;
			DIR_LEFT, DIR_NW, DIR_SW:  m = ~FILE_H;
			DIR_UP, DIR_DOWN:          m = '1;
		endcase
		return m;
	endfunction

	// Shift a bitboard n steps along direction d (n is 1, 2 or 4)
	function automatic bb_t dir_shift(bb_t x, dir_t d, logic [2:0] n);
		logic [5:0] amt;
		bb_t        r;
		unique case (d)
			DIR_UP, DIR_DOWN:    amt = {n, 3'b000};
			DIR_RIGHT, DIR_LEFT: amt = {3'b000, n};
			DIR_NE, DIR_SW:      amt = {n, 3'b000} + {3'b000, n};
			DIR_NW, DIR_SE:      amt = {n, 3'b000} - {3'b000, n};
		endcase
		unique case (d)
			DIR_UP, DIR_RIGHT, DIR_NE, DIR_NW:  r = x << amt;
			DIR_DOWN, DIR_LEFT, DIR_SE, DIR_SW: r = x >> amt;
		endcase
		return r;
	endfunction

endpackage

// ----- src/sray_req_if.sv -----
// ----------------------------------------------------------------------------
// sray_req_if
// Request channel: origin square and board occupancy, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sray_req_if;
	logic              valid;
	logic              ready;
	sray_pkg::square_t square;
	sray_pkg::bb_t     occupancy;

	modport source (output valid, output square, output occupancy, input ready);
	modport sink   (input valid, input square, input occupancy, output ready);
endinterface

// ----- src/sray_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sray_rsp_if
// Response channel: orthogonal and diagonal attack masks, valid/ready.
// ----------------------------------------------------------------------------
interface sray_rsp_if;
	logic          valid;
	logic          ready;
	sray_pkg::bb_t orthogonal_attacks;
	sray_pkg::bb_t diagonal_attacks;

	modport source (output valid, output orthogonal_attacks, output diagonal_attacks,
		input ready);
	modport sink   (input valid, input orthogonal_attacks, input diagonal_attacks,
		output ready);
endinterface

// ----- src/sray_entry.sv -----
// ----------------------------------------------------------------------------
// sray_entry
// First pipeline stage: decodes the origin square and seeds the occluded
// fill of all eight rays from the occupancy mask.
// ----------------------------------------------------------------------------
module sray_entry (
	input  logic           clk,
	input  logic           arst_n,
	sray_req_if.sink       req,
	output logic           valid,
	output sray_pkg::fill_t fill,
	input  logic           ready
);

	logic            valid_s1;
	sray_pkg::fill_t fill_s1;
	sray_pkg::fill_t seed;
	sray_pkg::bb_t   origin;
	logic            advance;

	// Stage takes a request when empty or when its content moves on
	assign advance   = !valid_s1 || ready;
	assign req.ready = advance;

	// Seed: origin as generator, empty squares as propagator (wrap-masked)
	always_comb begin
		origin = sray_pkg::bb_t'(1) << req.square;
		for (int d = 0; d < sray_pkg::NUM_DIRS; d++) begin
			seed.gen[d] = origin;
			seed.pro[d] = ~req.occupancy & sray_pkg::wrap_mask(sray_pkg::dir_t'(d));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req.valid) begin
			fill_s1 <= seed;
		end
	end

	assign valid = valid_s1;
	assign fill  = fill_s1;

endmodule

// ----- src/sray_fill_step.sv -----
// ----------------------------------------------------------------------------
// sray_fill_step
// One doubling step of the parallel-prefix occluded fill for all eight rays.
// The step input selects the stride: 1, 2 or 4 squares.
// ----------------------------------------------------------------------------
module sray_fill_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      step,
	input  logic            in_valid,
	output logic            in_ready,
	input  sray_pkg::fill_t in_fill,
	output logic            out_valid,
	input  logic            out_ready,
	output sray_pkg::fill_t out_fill
);

	logic            valid_s1;
	sray_pkg::fill_t fill_s1;
	sray_pkg::fill_t fill_next;
	logic [2:0]      stride;
	logic            advance;

	assign advance  = !valid_s1 || out_ready;
	assign in_ready = advance;
	assign stride   = 3'b001 << step;

	// Extend generators across runs of empty squares, then double the runs
	always_comb begin
		for (int d = 0; d < sray_pkg::NUM_DIRS; d++) begin
			fill_next.gen[d] = in_fill.gen[d] | (in_fill.pro[d] &
				sray_pkg::dir_shift(in_fill.gen[d], sray_pkg::dir_t'(d), stride));
			fill_next.pro[d] = in_fill.pro[d] &
				sray_pkg::dir_shift(in_fill.pro[d], sray_pkg::dir_t'(d), stride);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			fill_s1 <= fill_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_fill  = fill_s1;

endmodule

// ----- src/sray_collect.sv -----
// ----------------------------------------------------------------------------
// sray_collect
// Last pipeline stage: moves each filled ray one square onward (taking in
// the first blocker), drops wrapped squares and merges rays into two masks.
// ----------------------------------------------------------------------------
module sray_collect (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sray_pkg::fill_t in_fill,
	sray_rsp_if.source      rsp
);

	logic          valid_s1;
	sray_pkg::bb_t orth_s1;
	sray_pkg::bb_t diag_s1;
	sray_pkg::bb_t orth_next;
	sray_pkg::bb_t diag_next;
	logic          advance;

	assign advance  = !valid_s1 || rsp.ready;
	assign in_ready = advance;

	// Orthogonal rays are directions 0..3, diagonal ones 4..7
	always_comb begin
		orth_next = '0;
		diag_next = '0;
		for (int d = 0; d < sray_pkg::NUM_DIRS; d++) begin
			if (d < sray_pkg::NUM_DIRS / 2) begin
				orth_next |= sray_pkg::dir_shift(in_fill.gen[d], sray_pkg::dir_t'(d), 3'd1)
					& sray_pkg::wrap_mask(sray_pkg::dir_t'(d));
			end else begin
				diag_next |= sray_pkg::dir_shift(in_fill.gen[d], sray_pkg::dir_t'(d), 3'd1)
					& sray_pkg::wrap_mask(sray_pkg::dir_t'(d));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			orth_s1 <= orth_next;
			diag_s1 <= diag_next;
		end
	end

	assign rsp.valid              = valid_s1;
	assign rsp.orthogonal_attacks = orth_s1;
	assign rsp.diagonal_attacks   = diag_s1;

endmodule

// ----- src/sliding_ray_attack_generator_top.sv -----
// ----------------------------------------------------------------------------
// sliding_ray_attack_generator_top
// Sliding piece attack masks with blockers, via a pipelined occluded fill.
// ----------------------------------------------------------------------------
// Pipeline: five register stages from request accept to response valid
// (seed, three fill steps of stride 1/2/4, collect).
// Throughput: one request per cycle while rsp.ready holds; every stage has
// its own valid bit and fills bubbles while the response side stalls.
// Reset: arst_n clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module sliding_ray_attack_generator_top (
	input  logic       clk,
	input  logic       arst_n,
	sray_req_if.sink   req,
	sray_rsp_if.source rsp
);

	logic            valid_s1, valid_s2, valid_s3, valid_s4;
	logic            ready_s1, ready_s2, ready_s3, ready_s4;
	sray_pkg::fill_t fill_s1, fill_s2, fill_s3, fill_s4;

	// Seed stage
	sray_entry u_entry (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.valid  (valid_s1),
		.fill   (fill_s1),
		.ready  (ready_s1)
	);

	// Fill, stride 1
	sray_fill_step u_fill_1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (2'd0),
		.in_valid  (valid_s1),
		.in_ready  (ready_s1),
		.in_fill   (fill_s1),
		.out_valid (valid_s2),
		.out_ready (ready_s2),
		.out_fill  (fill_s2)
	);

	// Fill, stride 2
	sray_fill_step u_fill_2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (2'd1),
		.in_valid  (valid_s2),
		.in_ready  (ready_s2),
		.in_fill   (fill_s2),
		.out_valid (valid_s3),
		.out_ready (ready_s3),
		.out_fill  (fill_s3)
	);

	// Fill, stride 4
	sray_fill_step u_fill_4 (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (2'd2),
		.in_valid  (valid_s3),
		.in_ready  (ready_s3),
		.in_fill   (fill_s3),
		.out_valid (valid_s4),
		.out_ready (ready_s4),
		.out_fill  (fill_s4)
	);

	// Final step and merge into the two response masks
	sray_collect u_collect (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s4),
		.in_ready (ready_s4),
		.in_fill  (fill_s4),
		.rsp      (rsp)
	);

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks sliding_ray_attack_generator_top against a behavioral ray caster.
// Each accepted request is expanded into its orthogonal and diagonal masks in
// the testbench. Responses are matched in order against those masks. The
// sender works in random bursts. The receiver stalls in several patterns,
// including one long hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module testbench;

	localparam int BOARD_SIDE  = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT  = 4000;
	localparam int DRAIN_WAIT  = 12;

	typedef struct packed {
		sray_pkg::bb_t orth;
		sray_pkg::bb_t diag;
	} attack_pair_t;

	typedef enum int {RX_ALWAYS, RX_LIGHT, RX_HEAVY, RX_RUNS} rx_mode_t;

	logic clk;
	logic arst_n;

	sray_req_if req_ch ();
	sray_rsp_if rsp_ch ();

	sliding_ray_attack_generator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	attack_pair_t pending_masks[$];
	int           mismatch_count = 0;
	int           queries_sent   = 0;
	int           masks_checked  = 0;

	// sender burst shaping; gap_max of zero means back-to-back requests
	int           gap_max    = 0;
	int           burst_left = 0;

	// receiver control
	rx_mode_t     rx_mode  = RX_ALWAYS;
	bit           hold_req = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// one ray from the origin, stopping on the first blocker or at the edge
	function automatic sray_pkg::bb_t cast_line(sray_pkg::square_t sq, sray_pkg::bb_t occ,
		sray_pkg::dir_t d);
		int            r;
		int            f;
		int            dr;
		int            df;
		bit            blocked;
		sray_pkg::bb_t acc;
		dr = 0;
		df = 0;
		case (d)
			sray_pkg::DIR_UP:    dr = 1;
			sray_pkg::DIR_DOWN:  dr = -1;
			sray_pkg::DIR_RIGHT: df = 1;
			sray_pkg::DIR_LEFT:  df = -1;
			sray_pkg::DIR_NE: begin
				dr = 1;
				df = 1;
			end
			sray_pkg::DIR_NW: begin
				dr = 1;
				df = -1;
			end
			sray_pkg::DIR_SE: begin
				dr = -1;
				df = 1;
			end
			sray_pkg::DIR_SW: begin
				dr = -1;
				df = -1;
			end
		endcase
		acc     = '0;
		blocked = 1'b0;
		r       = int'(sq[5:3]) + dr;
		f       = int'(sq[2:0]) + df;
		while (!blocked && r >= 0 && r < BOARD_SIDE && f >= 0 && f < BOARD_SIDE) begin
			acc[r*BOARD_SIDE + f] = 1'b1;
			blocked = occ[r*BOARD_SIDE + f];
			r += dr;
			f += df;
		end
		return acc;
	endfunction

	// both attack masks for one square; orthogonal directions come first
	function automatic attack_pair_t slide_attacks(sray_pkg::square_t sq, sray_pkg::bb_t occ);
		attack_pair_t   p;
		sray_pkg::dir_t d;
		p = '0;
		for (int i = 0; i < sray_pkg::NUM_DIRS; i++) begin
			d = sray_pkg::dir_t'(i);
			if (d < sray_pkg::DIR_NE)
				p.orth |= cast_line(sq, occ, d);
			else
				p.diag |= cast_line(sq, occ, d);
		end
		return p;
	endfunction

	// boards of mixed density so rays stop at every distance
	function automatic sray_pkg::bb_t random_board();
		sray_pkg::bb_t a;
		sray_pkg::bb_t b;
		sray_pkg::bb_t c;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		case ($urandom_range(0, 4))
			0:       return a;
			1:       return a & b;
			2:       return a & b & c;
			3:       return a | b;
			default: return a & b & c & {$urandom, $urandom};
		endcase
	endfunction

	// drive one request and hold it until accepted, then maybe pause
	task automatic send_query(input sray_pkg::square_t sq, input sray_pkg::bb_t occ);
		int gap;
		req_ch.valid     <= 1'b1;
		req_ch.square    <= sq;
		req_ch.occupancy <= occ;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		queries_sent++;
		if (gap_max > 0) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				gap = $urandom_range(1, gap_max);
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(0, 12);
			end
		end
	endtask

	// receiver: stall pattern per mode, or a long hold-off on demand
	initial begin : receiver
		int hold_left;
		int run_left;
		bit level;
		hold_left = 0;
		run_left  = 0;
		level     = 1'b1;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: rsp_ch.ready <= 1'b1;
					RX_LIGHT:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					RX_HEAVY:  rsp_ch.ready <= ($urandom_range(0, 2) == 0);
					default: begin
						if (run_left == 0) begin
							level    = ~level;
							run_left = $urandom_range(1, 8);
						end
						run_left--;
						rsp_ch.ready <= level;
					end
				endcase
			end
		end
	end

	// record each accepted request and compare each accepted response
	always @(posedge clk) begin
		attack_pair_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				pending_masks.push_back(slide_attacks(req_ch.square, req_ch.occupancy));
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_masks.size() == 0) begin
					mismatch_count++;
					$display("%0t: response with no request pending: orth %h diag %h",
						$time, rsp_ch.orthogonal_attacks, rsp_ch.diagonal_attacks);
				end else begin
					want = pending_masks.pop_front();
					masks_checked++;
					if (rsp_ch.orthogonal_attacks !== want.orth) begin
						mismatch_count++;
						$display("%0t: orthogonal_attacks expected %h actual %h",
							$time, want.orth, rsp_ch.orthogonal_attacks);
					end
					if (rsp_ch.diagonal_attacks !== want.diag) begin
						mismatch_count++;
						$display("%0t: diagonal_attacks expected %h actual %h",
							$time, want.diag, rsp_ch.diagonal_attacks);
					end
				end
			end
		end
	end

	// watchdog: too long without any handshake ends the run
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: timeout, no handshake for %0d cycles", $time, IDLE_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// corners, edges, empty and full boards, occupied origin, wrap traps
	task automatic test_directed();
		gap_max = 0;
		rx_mode = RX_ALWAYS;
		send_query(6'd0, '0);
		send_query(6'd7, '0);
		send_query(6'd56, '0);
		send_query(6'd63, '0);
		send_query(6'd0, '1);
		send_query(6'd63, '1);
		send_query(6'd27, '0);
		send_query(6'd27, '1);
		// origin occupied, nothing else on the board
		send_query(6'd36, sray_pkg::bb_t'(1) << 36);
		send_query(6'd8, '0);
		send_query(6'd15, '0);
		send_query(6'd3, '0);
		send_query(6'd60, '0);
		// blockers on every neighbor of the origin
		send_query(6'd27, 64'h0000_001C_141C_0000);
		// blockers only on the board rim
		send_query(6'd27, 64'hFF81_8181_8181_81FF);
		// a blocker just across the file edge must not stop the right ray
		send_query(6'd7, sray_pkg::bb_t'(1) << 8);
		send_query(6'd7, '1);
		send_query(6'd56, sray_pkg::bb_t'(1) << 55);
	endtask

	// random boards under changing sender and receiver pacing
	task automatic test_random_boards(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				case ($urandom_range(0, 2))
					0:       gap_max = 0;
					1:       gap_max = 4;
					default: gap_max = 16;
				endcase
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			end
			send_query(sray_pkg::square_t'($urandom_range(0, 63)), random_board());
		end
	endtask

	// full rate on both sides
	task automatic test_back_to_back(input int count);
		gap_max = 0;
		rx_mode = RX_ALWAYS;
		for (int i = 0; i < count; i++)
			send_query(sray_pkg::square_t'($urandom_range(0, 63)), random_board());
	endtask

	// receiver holds off while requests keep coming, so the input stalls
	task automatic test_output_backpressure(input int count);
		gap_max  = 0;
		rx_mode  = RX_LIGHT;
		hold_req = 1'b1;
		for (int i = 0; i < count; i++)
			send_query(sray_pkg::square_t'($urandom_range(0, 63)), random_board());
	endtask

	// stimulus and final verdict
	initial begin
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.square    <= '0;
		req_ch.occupancy <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_boards(500);
		test_back_to_back(150);
		test_output_backpressure(100);

		req_ch.valid <= 1'b0;
		while (pending_masks.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d requests: corner, edge and rim cases, empty and full boards,",
			queries_sent);
		$display("random boards of mixed density, bursty and stalled traffic; %0d responses",
			masks_checked);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
src/sray_pkg.sv
src/sray_req_if.sv
src/sray_rsp_if.sv
src/sray_entry.sv
src/sray_fill_step.sv
src/sray_collect.sv
src/sliding_ray_attack_generator_top.sv
tb/testbench.sv
